/* rtl/mxs_pkg.sv */
package mxs_pkg;

    // Stack geometry.
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 7;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_POPMAX = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Control of the shared compare unit.
    typedef struct packed {
        logic en;
        logic first;
    } cmp_ctrl_t;

endpackage

/* rtl/mxs_ram.sv */
module mxs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mxs_cmp.sv */
module mxs_cmp
    import mxs_pkg::*;
(
    input  logic                     clk,
    input  cmp_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] data,
    input  logic [ADDR_W-1:0]        idx,
    output logic signed [DATA_W-1:0] best_val,
    output logic [ADDR_W-1:0]        best_idx,
    output logic signed [DATA_W-1:0] last_val
);

    logic signed [DATA_W-1:0] best_val_reg;
    logic [ADDR_W-1:0]        best_idx_reg;
    logic signed [DATA_W-1:0] last_val_reg;
    logic                     take;

    // A later entry wins ties, so the topmost maximum is kept.
    assign take = ctrl.first || (data >= best_val_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            last_val_reg <= data;
            if (take)
            begin
                best_val_reg <= data;
                best_idx_reg <= idx;
            end
        end
    end

    assign best_val = best_val_reg;
    assign best_idx = best_idx_reg;
    assign last_val = last_val_reg;

endmodule

/* rtl/max_stack.sv */
// Bounded stack of signed 32-bit values that also reports its maximum.
// A command beat is taken at a rising edge where start is high and busy is
// low; operation selects push, pop of the top entry, or removal of the
// topmost entry equal to the maximum, and value carries the pushed word.
// Each command yields exactly one result beat: done is high for one cycle
// while removed, status, top_value, max_value and count are valid. The
// receiver cannot stall, so the result must be taken in that cycle.
// The timing of each command is set by the single read port of the entry
// memory: every command ends with a walk over the held entries through one
// compare unit, and pop_max adds a search walk and, unless the maximum is
// the top entry, a shift walk on the same port.
// busy is high through the done cycle, so the next command is taken only
// after the block has returned to idle.
// Reset empties the stack; no clearing pass is needed since only entries
// below the fill count are ever read.
module max_stack
    import mxs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic signed [DATA_W-1:0] removed,
    output logic [ST_W-1:0]          status,
    output logic signed [DATA_W-1:0] top_value,
    output logic signed [DATA_W-1:0] max_value,
    output logic [COUNT_W-1:0]       count
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POPRD = 7'b0000010,
        S_FIND  = 7'b0000100,
        S_FEND  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [CNT_W-1:0]         iss_reg, iss_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [ST_W-1:0]          status_reg, status_next;
    logic signed [DATA_W-1:0] removed_reg, removed_next;

    logic [CNT_W-1:0]         fill_m1;
    logic                     full;
    logic                     empty;
    logic                     walking;
    logic                     issue;
    logic                     last_hit;
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [DATA_W-1:0]        wdata;
    logic [ADDR_W-1:0]        raddr;
    logic [DATA_W-1:0]        rdata;
    cmp_ctrl_t                cmp_ctrl;
    logic signed [DATA_W-1:0] best_val;
    logic [ADDR_W-1:0]        best_idx;
    logic signed [DATA_W-1:0] last_val;

    assign fill_m1 = fill_reg - CNT_W'(1);
    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);

    // Address issue for the memory walks.
    assign walking  = (state_reg == S_FIND) || (state_reg == S_SCAN) ||
                      (state_reg == S_SHIFT);
    assign issue    = walking && (iss_reg < fill_reg);
    assign last_hit = rd_vld_reg && (rd_idx_reg == fill_m1[ADDR_W-1:0]);
    assign raddr    = (state_reg == S_IDLE) ? fill_m1[ADDR_W-1:0]
                                            : iss_reg[ADDR_W-1:0];

    // Compare unit takes each returned word during the search and final walks.
    assign cmp_ctrl.en    = rd_vld_reg && ((state_reg == S_FIND) ||
                                           (state_reg == S_SCAN));
    assign cmp_ctrl.first = (rd_idx_reg == '0);

    mxs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    mxs_cmp u_cmp (
        .clk      (clk),
        .ctrl     (cmp_ctrl),
        .data     ($signed(rdata)),
        .idx      (rd_idx_reg),
        .best_val (best_val),
        .best_idx (best_idx),
        .last_val (last_val)
    );

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        iss_next     = iss_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        we           = 1'b0;
        waddr        = fill_reg[ADDR_W-1:0];
        wdata        = value;
        rd_vld_next  = issue;
        rd_idx_next  = iss_reg[ADDR_W-1:0];
        if (issue)
        begin
            iss_next = iss_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    removed_next = '0;
                    status_next  = ST_OK;
                    iss_next     = '0;
                    state_next   = S_SCAN;
                    case (operation)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we        = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POPRD;
                            end
                        end
                        OP_POPMAX:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_POPRD:
            begin
                removed_next = $signed(rdata);
                fill_next    = fill_m1;
                state_next   = S_SCAN;
            end
            S_FIND:
            begin
                if (last_hit)
                begin
                    state_next = S_FEND;
                end
            end
            S_FEND:
            begin
                removed_next = best_val;
                if (best_idx == fill_m1[ADDR_W-1:0])
                begin
                    fill_next  = fill_m1;
                    iss_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    iss_next   = CNT_W'(best_idx) + CNT_W'(1);
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // Each word above the removed entry moves down one place.
                if (rd_vld_reg)
                begin
                    we    = 1'b1;
                    waddr = rd_idx_reg - ADDR_W'(1);
                    wdata = rdata;
                end
                if (last_hit)
                begin
                    fill_next  = fill_m1;
                    iss_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (empty || last_hit)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            iss_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            iss_reg    <= iss_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // Result beat.
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign removed   = removed_reg;
    assign status    = status_reg;
    assign top_value = empty ? '0 : last_val;
    assign max_value = empty ? '0 : best_val;
    assign count     = COUNT_W'(fill_reg);

endmodule

/* rtl/mxs_check.sv */
module mxs_check
    import mxs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic [ST_W-1:0]          status,
    input logic signed [DATA_W-1:0] top_value,
    input logic signed [DATA_W-1:0] max_value,
    input logic [COUNT_W-1:0]       count
);

    // An accepted command holds the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");

    // A result beat lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An empty error can only be reported with an empty stack.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (count == '0))
        else $error("empty status with entries held");

    // A full error can only be reported with a full stack.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (count == COUNT_W'(DEPTH)))
        else $error("full status with room left");

    // An empty stack reports zero top and maximum.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (count == '0)) |-> ((top_value == '0) && (max_value == '0)))
        else $error("nonzero top or maximum on an empty stack");

endmodule

bind max_stack mxs_check u_mxs_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .top_value (top_value),
    .max_value (max_value),
    .count     (count)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import mxs_pkg::*;

    // The one operation code that the package leaves unnamed.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 3 * DEPTH + 20;
    localparam int N_DIRECTED   = 21;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed;
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] max_value;
        logic [COUNT_W-1:0]       count;
    } stack_result_t;

    // One directed command; when typed is set the w_* fields are the
    // expected result, otherwise the stack predictor supplies it.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        logic                     typed;
        logic signed [DATA_W-1:0] w_removed;
        logic [ST_W-1:0]          w_status;
        logic signed [DATA_W-1:0] w_top;
        logic signed [DATA_W-1:0] w_max;
        logic [COUNT_W-1:0]       w_count;
    } cmd_row_t;

    localparam cmd_row_t DIRECTED_CMDS [N_DIRECTED] = '{
        // Errors and the unused code on the empty stack after reset.
        '{OP_POP,    32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 32'h0, 32'h0, 7'd0},
        '{OP_POPMAX, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 32'h0, 32'h0, 7'd0},
        '{OP_UNUSED, 32'h0000_0000, 1'b1, 32'h0, ST_OK,    32'h0, 32'h0, 7'd0},
        // Both signed extremes, then a duplicate of the maximum.
        '{OP_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h0, ST_OK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd1},
        '{OP_PUSH, 32'h8000_0000, 1'b1, 32'h0, ST_OK, 32'h8000_0000, 32'h7FFF_FFFF, 7'd2},
        '{OP_PUSH,   32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_PUSH,   32'h7FFF_FFFF, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_PUSH,   32'h0000_0000, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_UNUSED, 32'hAAAA_AAAA, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        // Topmost of two equal maxima, then the bottom entry with a full shift.
        '{OP_POPMAX, 32'h0000_0000, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_POPMAX, 32'h5555_5555, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_POP,    32'h0000_0000, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_PUSH,   32'hFFFF_FFFB, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_PUSH,   32'hFFFF_FFFB, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_POPMAX, 32'h0000_0000, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_POPMAX, 32'h0000_0000, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_POP,    32'h0000_0000, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        // Emptying the stack again, then pop_max of the last entry.
        '{OP_POP, 32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_POP, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 32'h0, 32'h0, 7'd0},
        '{OP_PUSH, 32'h0000_0001, 1'b0, 32'h0, ST_OK, 32'h0, 32'h0, 7'd0},
        '{OP_POPMAX, 32'h0000_0000, 1'b1, 32'h1, ST_OK, 32'h0, 32'h0, 7'd0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          operation = OP_PUSH;
    logic signed [DATA_W-1:0] value = '0;
    logic                     done;
    logic signed [DATA_W-1:0] removed;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] max_value;
    logic [COUNT_W-1:0]       count;

    // Predictor copy of the stack contents.
    logic signed [DATA_W-1:0] model_entries [DEPTH];
    int                       model_fill = 0;

    stack_result_t results_due [$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;

    always #1 clk = ~clk;

    max_stack uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .value     (value),
        .done      (done),
        .removed   (removed),
        .status    (status),
        .top_value (top_value),
        .max_value (max_value),
        .count     (count)
    );

    // Index of the highest held entry that equals the maximum.
    function automatic int topmost_max_at();
        int best;
        int i;
        best = 0;
        for (i = 1; i < model_fill; i++)
        begin
            if (model_entries[i] >= model_entries[best])
                best = i;
        end
        return best;
    endfunction

    // Applies one command to the predictor stack and returns its result beat.
    function automatic stack_result_t apply_stack_op(input logic [OP_W-1:0] op,
                                                     input logic signed [DATA_W-1:0] val);
        stack_result_t r;
        int            at;
        int            i;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (model_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    model_entries[model_fill] = val;
                    model_fill++;
                end
            end
            OP_POP:
            begin
                if (model_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    model_fill--;
                    r.removed = model_entries[model_fill];
                end
            end
            OP_POPMAX:
            begin
                if (model_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    at = topmost_max_at();
                    r.removed = model_entries[at];
                    for (i = at; i + 1 < model_fill; i++)
                        model_entries[i] = model_entries[i + 1];
                    model_fill--;
                end
            end
            default:
            begin
            end
        endcase
        if (model_fill > 0)
        begin
            r.top_value = model_entries[model_fill - 1];
            r.max_value = model_entries[topmost_max_at()];
        end
        r.count = COUNT_W'(model_fill);
        return r;
    endfunction

    // Presents one command beat and holds it until the block takes it.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                            input logic typed, input stack_result_t want);
        stack_result_t predicted;
        start     <= 1'b1;
        operation <= op;
        value     <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_stack_op(op, val);
        results_due.push_back(typed ? want : predicted);
    endtask

    // Sender pacing: bursts of back-to-back commands separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                               input logic [DATA_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Result checking against the oldest pending expectation, plus watchdog.
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result beat with nothing pending, removed %h, count %0d",
                         $time, removed, count);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("removed", want.removed, removed);
                check_field("status", DATA_W'(want.status), DATA_W'(status));
                check_field("top_value", want.top_value, top_value);
                check_field("max_value", want.max_value, max_value);
                check_field("count", DATA_W'(want.count), DATA_W'(count));
            end
        end
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("max_stack verification failed");
            $finish;
        end
    end

    // Reset, directed table, random segments, drain and verdict.
    initial
    begin
        cmd_row_t                 row;
        stack_result_t            want;
        int                       issued;
        int                       seg_left;
        int                       push_pct;
        int                       pick;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < N_DIRECTED; n++)
        begin
            row = DIRECTED_CMDS[n];
            want.removed   = row.w_removed;
            want.status    = row.w_status;
            want.top_value = row.w_top;
            want.max_value = row.w_max;
            want.count     = row.w_count;
            send_cmd(row.op, row.val, row.typed, want);
            pace_sender();
        end

        // Segments lean toward filling, draining or a balance; the first one
        // fills the stack so that pushes onto a full stack are seen early.
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued == 0)
            begin
                push_pct = 95;
                seg_left = 100;
            end
            else
            begin
                pick = $urandom_range(0, 2);
                push_pct = (pick == 0) ? 92 : (pick == 1) ? 12 : 50;
                seg_left = $urandom_range(30, 120);
            end
            while (seg_left > 0 && issued < RANDOM_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    op = OP_UNUSED;
                else if (pick < 3 + push_pct)
                    op = OP_PUSH;
                else
                    op = ($urandom_range(0, 1) == 0) ? OP_POP : OP_POPMAX;

                // Small values make equal maxima common; extremes and full
                // random words cover the rest of the range.
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    val = 32'h7FFF_FFFF;
                else if (pick == 1)
                    val = 32'h8000_0000;
                else if (pick < 5)
                    val = DATA_W'($urandom_range(0, 15)) - 8;
                else
                    val = $urandom();

                send_cmd(op, val, 1'b0, '0);
                pace_sender();
                seg_left--;
                issued++;
            end
        end

        start <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("max_stack verification clean");
        else
            $display("max_stack verification failed");
        $finish;
    end

endmodule
